FILE: hw/rtl/rls_pkg.sv
// shared types and constants for the run-length stack
// no dependencies
package rls_pkg;

	localparam int RUN_DEPTH = 64;
	localparam int LVL_W     = $clog2(RUN_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_HALTED    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_TOP  = 2'd2,
		ACT_SIZE = 2'd3
	} action_t;

	// control broadcast from the sequencer to the chain
	typedef struct packed {
		logic        push;
		logic        shift;
		logic        dec;
		logic [31:0] new_value;
		logic [31:0] new_count;
		logic [31:0] dec_amount;
	} rls_ctrl_t;

endpackage

FILE: hw/rtl/run_length_stack.sv
// run-length stack: push, top and size results are strobed the cycle after acceptance.
// a pop walks over cell 0 of the chain, consuming or shortening runs until its count is met;
// busy is high while the walk runs, and no new request is taken then.
// each result is shown for one cycle on done; the receiver cannot stall.
// arst_n clears capacity, run level, item total and the halted flag; run slots stay unset.
// depends on rls_pkg and rls_chain
module run_length_stack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] item_count,
	input  logic [31:0] item_value,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] top_value,
	output logic [31:0] total_size
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t                    state_q, state_d;
	logic [31:0]               cap_q;
	logic [rls_pkg::LVL_W-1:0] level_q, level_d;
	logic [31:0]               total_q, total_d;
	logic [31:0]               left_q, left_d;
	logic                      halted_q, halted_d;
	logic                      done_q, done_d;
	rls_pkg::status_t          status_q, status_d;
	logic [31:0]               topv_q, topv_d;
	logic [31:0]               size_q, size_d;
	rls_pkg::rls_ctrl_t        ctrl;
	logic [31:0]               chain_value;
	logic [31:0]               chain_count;
	logic                      accept;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? cap_q : 32'd0;

	assign busy   = (state_q == S_WALK);
	assign accept = start && !busy;

	rls_chain u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.top_value (chain_value),
		.top_count (chain_count)
	);

	always_comb begin
		state_d  = state_q;
		level_d  = level_q;
		total_d  = total_q;
		left_d   = left_q;
		halted_d = halted_q;
		done_d   = 1'b0;
		status_d = rls_pkg::ST_OK;
		topv_d   = 32'd0;
		size_d   = 32'd0;
		ctrl            = '0;
		ctrl.new_value  = item_value;
		ctrl.new_count  = item_count;
		ctrl.dec_amount = left_q;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					if (halted_q) begin
						status_d = rls_pkg::ST_HALTED;
					end else begin
						case (rls_pkg::action_t'(action))
							rls_pkg::ACT_PUSH: begin
								if (item_count == 32'd0) begin
									status_d = rls_pkg::ST_OK;
								end else if (({1'b0, total_q} + {1'b0, item_count})
										> {1'b0, cap_q}) begin
									status_d = rls_pkg::ST_FULL;
									halted_d = 1'b1;
								end else if (level_q
										>= rls_pkg::LVL_W'(rls_pkg::RUN_DEPTH)) begin
									status_d = rls_pkg::ST_EXHAUSTED;
								end else begin
									ctrl.push = 1'b1;
									level_d   = level_q + 1'b1;
									total_d   = total_q + item_count;
								end
							end
							rls_pkg::ACT_POP: begin
								if (item_count > total_q) begin
									status_d = rls_pkg::ST_EMPTY;
									halted_d = 1'b1;
								end else if (item_count != 32'd0) begin
									// result comes when the walk ends
									done_d  = 1'b0;
									total_d = total_q - item_count;
									left_d  = item_count;
									state_d = S_WALK;
								end
							end
							rls_pkg::ACT_TOP: begin
								if (level_q == '0) begin
									status_d = rls_pkg::ST_EMPTY;
									halted_d = 1'b1;
								end else begin
									topv_d = chain_value;
								end
							end
							rls_pkg::ACT_SIZE: begin
								size_d = total_q;
							end
							default: begin
								status_d = rls_pkg::ST_OK;
							end
						endcase
					end
				end
			end
			S_WALK: begin
				if (chain_count > left_q) begin
					ctrl.dec = 1'b1;
					left_d   = 32'd0;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					// whole top run consumed
					ctrl.shift = 1'b1;
					level_d    = level_q - 1'b1;
					left_d     = left_q - chain_count;
					if (left_q == chain_count) begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= 32'd0;
			level_q  <= '0;
			total_q  <= 32'd0;
			halted_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			level_q  <= level_d;
			total_q  <= total_d;
			halted_q <= halted_d;
			done_q   <= done_d;
			if (cfg_wr) begin
				cap_q <= pwdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		left_q   <= left_d;
		status_q <= status_d;
		topv_q   <= topv_d;
		size_q   <= size_d;
	end

	assign done       = done_q;
	assign status     = status_q;
	assign top_value  = topv_q;
	assign total_size = size_q;

`ifndef SYNTH
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= rls_pkg::LVL_W'(rls_pkg::RUN_DEPTH))
		else $error("run level beyond store depth");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (level_q != '0))
		else $error("pop walk on an empty run store");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q == '0) |-> (total_q == 32'd0))
		else $error("items counted with no runs held");

	a_halted_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && start && !busy) |=> (done && status == rls_pkg::ST_HALTED))
		else $error("halted block did not answer halted");
`endif

endmodule

FILE: hw/rtl/rls_cell.sv
// one run slot of the stack chain: holds a (value, count) pair
// depends on rls_pkg
module rls_cell (
	input  logic               clk,
	input  rls_pkg::rls_ctrl_t ctrl,
	input  logic               dec_en,
	input  logic [31:0]        above_value,
	input  logic [31:0]        above_count,
	input  logic [31:0]        below_value,
	input  logic [31:0]        below_count,
	output logic [31:0]        value,
	output logic [31:0]        count
);

	logic [31:0] value_q;
	logic [31:0] count_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			value_q <= above_value;
			count_q <= above_count;
		end else if (ctrl.shift) begin
			value_q <= below_value;
			count_q <= below_count;
		end else if (ctrl.dec && dec_en) begin
			count_q <= count_q - ctrl.dec_amount;
		end
	end

	assign value = value_q;
	assign count = count_q;

endmodule

FILE: hw/rtl/rls_chain.sv
// row of run cells; cell 0 is the top of the stack
// depends on rls_pkg and rls_cell
module rls_chain (
	input  logic               clk,
	input  rls_pkg::rls_ctrl_t ctrl,
	output logic [31:0]        top_value,
	output logic [31:0]        top_count
);

	logic [31:0] val_w [rls_pkg::RUN_DEPTH];
	logic [31:0] cnt_w [rls_pkg::RUN_DEPTH];

	for (genvar i = 0; i < rls_pkg::RUN_DEPTH; i++) begin : g_cell
		logic [31:0] av;
		logic [31:0] ac;
		logic [31:0] bv;
		logic [31:0] bc;

		if (i == 0) begin : g_first
			assign av = ctrl.new_value;
			assign ac = ctrl.new_count;
		end else begin : g_mid
			assign av = val_w[i-1];
			assign ac = cnt_w[i-1];
		end

		// bottom cell pulls in nothing when runs move up
		if (i == rls_pkg::RUN_DEPTH - 1) begin : g_last
			assign bv = '0;
			assign bc = '0;
		end else begin : g_inner
			assign bv = val_w[i+1];
			assign bc = cnt_w[i+1];
		end

		rls_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.dec_en      (i == 0),
			.above_value (av),
			.above_count (ac),
			.below_value (bv),
			.below_count (bc),
			.value       (val_w[i]),
			.count       (cnt_w[i])
		);
	end

	assign top_value = val_w[0];
	assign top_count = cnt_w[0];

endmodule

FILE: sim/testbench.sv
// testbench for run_length_stack: directed and random requests, capacity writes over apb,
// each answer checked against a local prediction of the run store
// depends on rls_pkg and run_length_stack
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rls_pkg::*;

	localparam logic [2:0] CAPACITY_ADDR = 3'd0;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef enum int {
		HALT_BY_FULL,
		HALT_BY_POP,
		HALT_BY_TOP
	} halt_cause_t;

	typedef struct {
		status_t     status;
		logic [31:0] top_value;
		logic [31:0] total_size;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [31:0] item_count;
	logic [31:0] item_value;
	logic        done;
	logic [2:0]  status;
	logic [31:0] top_value;
	logic [31:0] total_size;

	// local copy of the stack and its register
	logic [31:0] cap_reg;
	logic [31:0] run_val [RUN_DEPTH];
	logic [31:0] run_cnt [RUN_DEPTH];
	int unsigned depth_used;
	logic [31:0] held_items;
	bit          halted;

	answer_t     pending_answers[$];
	int          error_count;
	int          requests_sent;
	int          answers_checked;
	int          exhausted_seen;
	int          deepest_pop;
	bit          gap_free;
	halt_cause_t halt_cause;

	run_length_stack u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.item_count (item_count),
		.item_value (item_value),
		.done       (done),
		.status     (status),
		.top_value  (top_value),
		.total_size (total_size)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= 50) begin
			$display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
		end
	endtask

	// applies one request to the local stack and returns the answer it should give
	function automatic answer_t predict_stack_answer(action_t act, logic [31:0] cnt,
			logic [31:0] val);
		answer_t     ans;
		logic [31:0] left;
		int          walked;
		ans.status = ST_OK;
		ans.top_value = '0;
		ans.total_size = '0;
		walked = 0;
		if (halted) begin
			ans.status = ST_HALTED;
		end else begin
			case (act)
				ACT_PUSH: begin
					if (cnt != 0) begin
						if ({1'b0, held_items} + {1'b0, cnt} > {1'b0, cap_reg}) begin
							halted = 1'b1;
							ans.status = ST_FULL;
						end else if (depth_used >= RUN_DEPTH) begin
							ans.status = ST_EXHAUSTED;
						end else begin
							run_val[depth_used] = val;
							run_cnt[depth_used] = cnt;
							depth_used++;
							held_items += cnt;
						end
					end
				end
				ACT_POP: begin
					if (cnt > held_items) begin
						halted = 1'b1;
						ans.status = ST_EMPTY;
					end else begin
						held_items -= cnt;
						left = cnt;
						while (left != 0 && depth_used != 0) begin
							walked++;
							if (run_cnt[depth_used-1] > left) begin
								run_cnt[depth_used-1] -= left;
								left = '0;
							end else begin
								left -= run_cnt[depth_used-1];
								depth_used--;
							end
						end
					end
				end
				ACT_TOP: begin
					if (depth_used == 0) begin
						halted = 1'b1;
						ans.status = ST_EMPTY;
					end else begin
						ans.top_value = run_val[depth_used-1];
					end
				end
				default: begin
					ans.total_size = held_items;
				end
			endcase
		end
		if (ans.status == ST_EXHAUSTED) exhausted_seen++;
		if (walked > deepest_pop) deepest_pop = walked;
		return ans;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_free || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic send_request(action_t act, logic [31:0] cnt, logic [31:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action <= act;
		item_count <= cnt;
		item_value <= val;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_answers.push_back(predict_stack_answer(act, cnt, val));
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_answers();
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write then read back over apb; only called with the block idle
	task automatic set_capacity(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cap_reg = value;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== cap_reg) report_mismatch("capacity readback", prdata, cap_reg);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin : answer_check
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("answer with no request waiting: status", status, '0);
			end else begin
				want = pending_answers.pop_front();
				answers_checked++;
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (top_value !== want.top_value) begin
					report_mismatch("top_value", top_value, want.top_value);
				end
				if (total_size !== want.total_size) begin
					report_mismatch("total_size", total_size, want.total_size);
				end
			end
		end
	end

	// capacity comes out of reset at zero, so only empty requests succeed
	task automatic test_reset_state();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAPACITY_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== '0) report_mismatch("capacity after reset", prdata, '0);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		send_request(ACT_PUSH, '0, $urandom);
		send_request(ACT_POP, '0, '0);
		send_request(ACT_SIZE, '0, '0);
		wait_for_answers();
	endtask

	task automatic test_push_pop_walk();
		set_capacity(ALL_ONES);
		send_request(ACT_PUSH, 32'd3, ALL_ONES);
		send_request(ACT_PUSH, 32'd5, '0);
		send_request(ACT_PUSH, 32'd1, 32'hA5A5_A5A5);
		send_request(ACT_TOP, '0, '0);
		send_request(ACT_SIZE, '0, '0);
		// takes the top run and shortens the one below
		send_request(ACT_POP, 32'd2, '0);
		send_request(ACT_TOP, '0, '0);
		send_request(ACT_POP, 32'd4, '0);
		send_request(ACT_TOP, '0, '0);
		send_request(ACT_POP, 32'd3, '0);
		send_request(ACT_SIZE, '0, '0);
		send_request(ACT_PUSH, ALL_ONES, 32'h5A5A_5A5A);
		send_request(ACT_SIZE, '0, '0);
		send_request(ACT_TOP, '0, '0);
		send_request(ACT_POP, ALL_ONES, '0);
		send_request(ACT_SIZE, '0, '0);
		wait_for_answers();
	endtask

	task automatic test_capacity_lowered();
		set_capacity(32'd10);
		send_request(ACT_PUSH, 32'd8, 32'h0000_0001);
		wait_for_answers();
		// items already held stay; only later pushes are limited
		set_capacity(32'd4);
		send_request(ACT_PUSH, '0, 32'h8000_0000);
		send_request(ACT_SIZE, '0, '0);
		send_request(ACT_TOP, '0, '0);
		send_request(ACT_POP, 32'd5, '0);
		send_request(ACT_PUSH, 32'd1, 32'h7FFF_FFFF);
		send_request(ACT_SIZE, '0, '0);
		wait_for_answers();
	endtask

	task automatic test_run_store_exhausted();
		set_capacity(ALL_ONES);
		while (depth_used < RUN_DEPTH) begin
			send_request(ACT_PUSH, $urandom_range(1, 100), $urandom);
		end
		send_request(ACT_PUSH, $urandom_range(1, 100), $urandom);
		send_request(ACT_PUSH, '0, $urandom);
		send_request(ACT_TOP, '0, '0);
		send_request(ACT_SIZE, '0, '0);
		// one pop across the whole run store
		send_request(ACT_POP, held_items, '0);
		send_request(ACT_SIZE, '0, '0);
		wait_for_answers();
	endtask

	function automatic logic [31:0] random_count();
		int m;
		m = $urandom_range(0, 9);
		if (m == 0) return '0;
		if (m < 6) return $urandom_range(1, 8);
		if (m < 8) return $urandom_range(1, 1000);
		return $urandom;
	endfunction

	// only requests that keep the stack out of the halted state
	task automatic send_random_request();
		int          r;
		logic [31:0] room;
		logic [31:0] cnt;
		logic [31:0] val;
		r = $urandom_range(0, 99);
		room = (cap_reg > held_items) ? cap_reg - held_items : '0;
		cnt = random_count();
		val = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
		if (r < 45) begin
			if (cnt > room) cnt = $urandom_range(0, room);
			send_request(ACT_PUSH, cnt, val);
		end else if (r < 75) begin
			if (cnt > held_items) cnt = $urandom_range(0, held_items);
			send_request(ACT_POP, cnt, val);
		end else if (r < 88 && depth_used != 0) begin
			send_request(ACT_TOP, cnt, val);
		end else begin
			send_request(ACT_SIZE, cnt, val);
		end
	endtask

	task automatic test_random_traffic();
		logic [31:0] caps [4];
		caps[0] = ALL_ONES;
		caps[1] = $urandom;
		caps[2] = $urandom_range(1, 400);
		caps[3] = $urandom_range(0, 40);
		for (int phase = 0; phase < 4; phase++) begin
			set_capacity(caps[phase]);
			gap_free = (phase == 1);
			for (int n = 0; n < 200; n++) begin
				send_random_request();
				if ($urandom_range(0, 49) == 0) wait_for_answers();
			end
			wait_for_answers();
		end
		gap_free = 1'b0;
	endtask

	// a full push, an over-long pop or a top on an empty stack halts the block for good, so this runs last
	task automatic test_halt();
		halt_cause = halt_cause_t'($urandom_range(0, 2));
		case (halt_cause)
			HALT_BY_FULL: begin
				set_capacity(held_items);
				send_request(ACT_PUSH, 32'd1, $urandom);
			end
			HALT_BY_POP: begin
				if (held_items == ALL_ONES) send_request(ACT_POP, 32'd1, '0);
				send_request(ACT_POP, $urandom_range(held_items + 1, ALL_ONES), '0);
			end
			default: begin
				send_request(ACT_POP, held_items, '0);
				send_request(ACT_TOP, '0, '0);
			end
		endcase
		for (int n = 0; n < 8; n++) begin
			send_request(action_t'(n % 4), $urandom, $urandom);
		end
		wait_for_answers();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		action = ACT_PUSH;
		item_count = '0;
		item_value = '0;
		cap_reg = '0;
		depth_used = 0;
		held_items = '0;
		halted = 1'b0;
		gap_free = 1'b0;
		error_count = 0;
		requests_sent = 0;
		answers_checked = 0;
		exhausted_seen = 0;
		deepest_pop = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_push_pop_walk();
		test_capacity_lowered();
		test_run_store_exhausted();
		test_random_traffic();
		test_halt();

		start <= 1'b0;
		for (int i = 0; i < 5000 && pending_answers.size() != 0; i++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_answers.size() != 0) begin
			report_mismatch("answers never arrived, count", pending_answers.size(), '0);
		end
		$display("covered %0d requests, %0d answers checked, %0d run store exhausted answers",
			requests_sent, answers_checked, exhausted_seen);
		$display("longest pop walked %0d runs; halted state entered by %s",
			deepest_pop, halt_cause.name());
		if (error_count == 0) begin
			$display("run_length_stack test passed");
		end else begin
			$display("run_length_stack test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d answers outstanding", pending_answers.size());
		$display("run_length_stack test failed");
		$finish;
	end

endmodule
